// ===== src/stes_pkg.sv =====
// Shared types, widths and small decode functions for the space truss element stiffness block.
// Used by every module of the block; depends on nothing.
package stes_pkg;

  localparam int AXES          = 3;
  localparam int DOF           = 2 * AXES;
  localparam int COORD_W       = 32;
  localparam int U_W           = 33;
  localparam int SUM_W         = 66;
  localparam int LEN_W         = 33;
  localparam int COS_W         = 25;
  localparam int COS_FRAC      = 24;
  localparam int MOD_W         = 48;
  localparam int AREA_W        = 32;
  localparam int PROD_W        = 80;
  localparam int NUM_W         = 88;
  localparam int STIFF_W       = 64;
  localparam int NODE_W        = 12;
  localparam int GDOF_W        = 14;
  localparam int PAIRS         = 6;
  localparam int QUEUE_DEPTH_DEF = 2;

  localparam logic [STIFF_W-1:0] POS_MAX = {1'b0, {(STIFF_W-1){1'b1}}};
  localparam logic [STIFF_W-1:0] NEG_MAX = {1'b1, {(STIFF_W-1){1'b0}}};
  localparam logic [2:0] LAST_DOF = 3'd5;

  // Everything the back end needs to expand one bar into its matrix entries.
  typedef struct packed {
    logic [AXES-1:0][COS_W-1:0] cosv;
    logic [AXES-1:0]            neg;
    logic [LEN_W-1:0]           len;
    logic [PROD_W-1:0]          prod;
    logic                       zero;
    logic [NODE_W-1:0]          node0;
    logic [NODE_W-1:0]          node1;
    logic [AXES-1:0]            fix0;
    logic [AXES-1:0]            fix1;
  } bar_t;

  // Node half of a local degree of freedom.
  function automatic logic dof_node(input logic [2:0] d);
    return (d >= 3'd3);
  endfunction

  // Axis of a local degree of freedom.
  function automatic logic [1:0] dof_axis(input logic [2:0] d);
    logic [2:0] t;
    t = (d >= 3'd3) ? d - 3'd3 : d;
    return t[1:0];
  endfunction

  // The cosine product table is symmetric, so six pairs cover all nine.
  function automatic logic [2:0] pair_index(input logic [1:0] a, input logic [1:0] b);
    logic [2:0] p;
    unique case ({a, b}) inside
      4'b0000:          p = 3'd0;
      4'b0001, 4'b0100: p = 3'd1;
      4'b0010, 4'b1000: p = 3'd2;
      4'b0101:          p = 3'd3;
      4'b0110, 4'b1001: p = 3'd4;
      4'b1010:          p = 3'd5;
      default:          p = 3'd0;
    endcase
    return p;
  endfunction

  function automatic logic [1:0] pair_first(input logic [2:0] p);
    logic [1:0] a;
    unique case (p) inside
      3'd0, 3'd1, 3'd2: a = 2'd0;
      3'd3, 3'd4:       a = 2'd1;
      default:          a = 2'd2;
    endcase
    return a;
  endfunction

  function automatic logic [1:0] pair_second(input logic [2:0] p);
    logic [1:0] b;
    unique case (p) inside
      3'd0:       b = 2'd0;
      3'd1, 3'd3: b = 2'd1;
      default:    b = 2'd2;
    endcase
    return b;
  endfunction

endpackage

// ===== src/stes_front.sv =====
// Front end: accepts a bar, forms the squared length, the bar length, the cosines and E*A.
// Depends on stes_pkg.
module stes_front (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic signed [31:0]           in_first_x,
  input  logic signed [31:0]           in_first_y,
  input  logic signed [31:0]           in_first_z,
  input  logic signed [31:0]           in_second_x,
  input  logic signed [31:0]           in_second_y,
  input  logic signed [31:0]           in_second_z,
  input  logic [47:0]                  in_modulus,
  input  logic [31:0]                  in_area,
  input  logic [11:0]                  in_first_node,
  input  logic [11:0]                  in_second_node,
  input  logic [2:0]                   in_first_fixed,
  input  logic [2:0]                   in_second_fixed,
  output logic                         bar_valid,
  input  logic                         bar_ready,
  output stes_pkg::bar_t               bar
);
  import stes_pkg::*;

  typedef enum logic [4:0] {
    F_IDLE  = 5'b00001,
    F_SUMSQ = 5'b00010,
    F_SQRT  = 5'b00100,
    F_COS   = 5'b01000,
    F_PUSH  = 5'b10000
  } fstate_t;

  fstate_t             state_r;
  logic [U_W-1:0]      u_r [AXES];
  logic [AXES-1:0]     neg_r;
  logic [MOD_W-1:0]    mod_r;
  logic [AREA_W-1:0]   area_r;
  logic [NODE_W-1:0]   node0_r, node1_r;
  logic [AXES-1:0]     fix0_r, fix1_r;
  logic [1:0]          ax_r;
  logic [SUM_W-1:0]    sum_r, sq_r;
  logic [PROD_W-1:0]   prod_r;
  logic [35:0]         rem_r;
  logic [LEN_W-1:0]    root_r;
  logic [5:0]          it_r;
  logic [56:0]         dv_r;
  logic [32:0]         crem_r;
  logic [COS_W-1:0]    quo_r;
  logic [COS_W-1:0]    cos_r [AXES];
  logic [LEN_W-1:0]    len_r;
  logic                zero_r;

  logic [U_W-1:0]      u_in [AXES];
  logic [AXES-1:0]     neg_in;
  logic [SUM_W-1:0]    sum_nxt;
  logic [35:0]         rem2, trial;
  logic                sq_ge;
  logic [LEN_W-1:0]    root_nxt;
  logic [33:0]         cr2;
  logic                c_ge;
  logic [COS_W-1:0]    quo_nxt;

  always_comb begin
    logic signed [32:0] d [AXES];
    d[0] = {in_second_x[31], in_second_x} - {in_first_x[31], in_first_x};
    d[1] = {in_second_y[31], in_second_y} - {in_first_y[31], in_first_y};
    d[2] = {in_second_z[31], in_second_z} - {in_first_z[31], in_first_z};
    for (int a = 0; a < AXES; a++) begin
      neg_in[a] = d[a][32];
      u_in[a]   = d[a][32] ? U_W'(-d[a]) : U_W'(d[a]);
    end
  end

  assign sum_nxt  = sum_r + SUM_W'(u_r[ax_r] * u_r[ax_r]);
  assign rem2     = {rem_r[33:0], sq_r[SUM_W-1:SUM_W-2]};
  assign trial    = {1'b0, root_r, 2'b01};
  assign sq_ge    = (rem2 >= trial);
  assign root_nxt = {root_r[LEN_W-2:0], sq_ge};
  assign cr2      = {crem_r, dv_r[56]};
  assign c_ge     = (cr2 >= {1'b0, len_r});
  assign quo_nxt  = {quo_r[COS_W-2:0], c_ge};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      unique case (state_r)
        F_IDLE: begin
          if (in_valid) begin
            for (int a = 0; a < AXES; a++) u_r[a] <= u_in[a];
            neg_r   <= neg_in;
            mod_r   <= in_modulus;
            area_r  <= in_area;
            node0_r <= in_first_node;
            node1_r <= in_second_node;
            fix0_r  <= in_first_fixed;
            fix1_r  <= in_second_fixed;
            ax_r    <= 2'd0;
            sum_r   <= '0;
            state_r <= F_SUMSQ;
          end
        end
        F_SUMSQ: begin
          sum_r <= sum_nxt;
          if (ax_r == 2'd0) begin
            prod_r <= PROD_W'(mod_r[31:0] * area_r);
          end else if (ax_r == 2'd1) begin
            prod_r <= prod_r + {(PROD_W-32)'(mod_r[47:32] * area_r), 32'b0};
          end
          if (ax_r == 2'd2) begin
            sq_r    <= sum_nxt;
            rem_r   <= '0;
            root_r  <= '0;
            it_r    <= 6'd32;
            state_r <= F_SQRT;
          end else begin
            ax_r <= ax_r + 2'd1;
          end
        end
        F_SQRT: begin
          rem_r  <= sq_ge ? rem2 - trial : rem2;
          root_r <= root_nxt;
          sq_r   <= {sq_r[SUM_W-3:0], 2'b00};
          if (it_r == 6'd0) begin
            zero_r  <= (sum_r == '0);
            len_r   <= (sum_r == '0) ? LEN_W'(1) : root_nxt;
            ax_r    <= 2'd0;
            dv_r    <= {u_r[0], 24'b0};
            crem_r  <= '0;
            quo_r   <= '0;
            it_r    <= 6'd56;
            state_r <= F_COS;
          end else begin
            it_r <= it_r - 6'd1;
          end
        end
        F_COS: begin
          if (it_r == 6'd0) begin
            cos_r[ax_r] <= quo_nxt;
            if (ax_r == 2'd2) begin
              state_r <= F_PUSH;
            end else begin
              ax_r   <= ax_r + 2'd1;
              dv_r   <= {u_r[ax_r + 2'd1], 24'b0};
              crem_r <= '0;
              quo_r  <= '0;
              it_r   <= 6'd56;
            end
          end else begin
            crem_r <= c_ge ? 33'(cr2 - {1'b0, len_r}) : 33'(cr2);
            quo_r  <= quo_nxt;
            dv_r   <= {dv_r[55:0], 1'b0};
            it_r   <= it_r - 6'd1;
          end
        end
        F_PUSH: begin
          if (bar_ready) state_r <= F_IDLE;
        end
        default: state_r <= F_IDLE;
      endcase
    end
  end

  assign in_ready  = (state_r == F_IDLE);
  assign bar_valid = (state_r == F_PUSH);

  always_comb begin
    for (int a = 0; a < AXES; a++) bar.cosv[a] = cos_r[a];
    bar.neg   = neg_r;
    bar.len   = len_r;
    bar.prod  = prod_r;
    bar.zero  = zero_r;
    bar.node0 = node0_r;
    bar.node1 = node1_r;
    bar.fix0  = fix0_r;
    bar.fix1  = fix1_r;
  end

endmodule

// ===== src/stes_queue.sv =====
// Short queue of prepared bars between the front end and the back end.
// Depends on stes_pkg.
module stes_queue #(
  parameter int DEPTH = stes_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           wr_valid,
  output logic           wr_ready,
  input  stes_pkg::bar_t wr_data,
  output logic           rd_valid,
  input  logic           rd_ready,
  output stes_pkg::bar_t rd_data
);
  import stes_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  bar_t               slot_r [DEPTH];
  logic [PTR_W-1:0]   wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]   count_r;
  logic               push, pop;

  assign wr_ready = (count_r != CNT_W'(DEPTH));
  assign rd_valid = (count_r != '0);
  assign push     = wr_valid && wr_ready;
  assign pop      = rd_valid && rd_ready;
  assign rd_data  = slot_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) slot_r[wr_ptr_r] <= wr_data;
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      if (pop)  rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      if (push && !pop)      count_r <= count_r + CNT_W'(1);
      else if (pop && !push) count_r <= count_r - CNT_W'(1);
    end
  end

  a_fill_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> (count_r == $past(count_r) + CNT_W'(1)))
    else $error("queue fill count did not follow a push");

endmodule

// ===== src/stes_back.sv =====
// Back end: forms the six distinct stiffness magnitudes of a bar and streams its 36 entries.
// Depends on stes_pkg.
module stes_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           bar_valid,
  output logic           bar_ready,
  input  stes_pkg::bar_t bar,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [2:0]     out_local_row,
  output logic [2:0]     out_local_col,
  output logic [13:0]    out_global_row,
  output logic [13:0]    out_global_col,
  output logic           out_row_is_fixed,
  output logic           out_col_is_fixed,
  output logic signed [63:0] out_stiffness,
  output logic           out_zero_length,
  output logic           out_last_entry
);
  import stes_pkg::*;

  typedef enum logic [3:0] {
    B_IDLE = 4'b0001,
    B_MUL  = 4'b0010,
    B_DIV  = 4'b0100,
    B_EMIT = 4'b1000
  } bstate_t;

  bstate_t             state_r;
  bar_t                bar_r;
  logic [2:0]          pair_r;
  logic                ph_r;
  logic [1:0]          k_r;
  logic [127:0]        a_r, acc_r;
  logic [NUM_W-1:0]    dv_r, quo_r;
  logic [32:0]         drem_r;
  logic [6:0]          dcnt_r;
  logic [STIFF_W-1:0]  mag_r [PAIRS];
  logic [2:0]          row_r, col_r;
  logic                out_valid_r;

  logic [COS_W-1:0]    bsel;
  logic [127:0]        acc_nxt;
  logic                mul_done;
  logic [33:0]         dr2;
  logic                d_ge;
  logic [NUM_W-1:0]    quo_nxt;
  logic                sat;
  logic                out_adv;

  // Partial product of one 32-bit slice of the wide operand, placed at its weight.
  assign bsel     = ph_r ? bar_r.cosv[pair_second(pair_r)] : bar_r.cosv[pair_first(pair_r)];
  assign acc_nxt  = acc_r + (128'(a_r[{k_r, 5'b0} +: 32] * bsel) << {k_r, 5'b0});
  assign mul_done = ph_r ? (k_r == 2'd3) : (k_r == 2'd2);

  assign dr2     = {drem_r, dv_r[NUM_W-1]};
  assign d_ge    = (dr2 >= {1'b0, bar_r.len});
  assign quo_nxt = {quo_r[NUM_W-2:0], d_ge};
  assign sat     = (|quo_nxt[NUM_W-1:STIFF_W]) || (quo_nxt[STIFF_W-1:0] > NEG_MAX);

  assign out_adv   = !out_valid_r || out_ready;
  assign bar_ready = (state_r == B_IDLE);
  assign out_valid = out_valid_r;

  // One matrix entry from the current row and column.
  logic                rn, cn, neg_e;
  logic [1:0]          ra, ca;
  logic [STIFF_W-1:0]  m, val;
  logic [NODE_W-1:0]   nr, nc;

  always_comb begin
    rn    = dof_node(row_r);
    cn    = dof_node(col_r);
    ra    = dof_axis(row_r);
    ca    = dof_axis(col_r);
    m     = bar_r.zero ? '0 : mag_r[pair_index(ra, ca)];
    neg_e = (bar_r.neg[ra] ^ bar_r.neg[ca]) ^ (rn ^ cn);
    if (neg_e) val = '0 - m;
    else       val = m[STIFF_W-1] ? POS_MAX : m;
    nr    = rn ? bar_r.node1 : bar_r.node0;
    nc    = cn ? bar_r.node1 : bar_r.node0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      // While streaming, the output register is refilled whenever it drains.
      if (out_ready && state_r != B_EMIT) out_valid_r <= 1'b0;
      unique case (state_r)
        B_IDLE: begin
          if (bar_valid) begin
            bar_r   <= bar;
            pair_r  <= '0;
            ph_r    <= 1'b0;
            k_r     <= '0;
            a_r     <= 128'(bar.prod);
            acc_r   <= '0;
            state_r <= B_MUL;
          end
        end
        B_MUL: begin
          if (mul_done && ph_r) begin
            dv_r    <= acc_nxt[127:40];
            quo_r   <= '0;
            drem_r  <= '0;
            dcnt_r  <= 7'(NUM_W - 1);
            state_r <= B_DIV;
          end else if (mul_done) begin
            ph_r  <= 1'b1;
            k_r   <= '0;
            a_r   <= acc_nxt;
            acc_r <= '0;
          end else begin
            acc_r <= acc_nxt;
            k_r   <= k_r + 2'd1;
          end
        end
        B_DIV: begin
          drem_r <= d_ge ? 33'(dr2 - {1'b0, bar_r.len}) : 33'(dr2);
          quo_r  <= quo_nxt;
          dv_r   <= {dv_r[NUM_W-2:0], 1'b0};
          dcnt_r <= dcnt_r - 7'd1;
          if (dcnt_r == '0) begin
            mag_r[pair_r] <= sat ? NEG_MAX : quo_nxt[STIFF_W-1:0];
            if (pair_r == 3'(PAIRS - 1)) begin
              row_r   <= '0;
              col_r   <= '0;
              state_r <= B_EMIT;
            end else begin
              pair_r  <= pair_r + 3'd1;
              ph_r    <= 1'b0;
              k_r     <= '0;
              a_r     <= 128'(bar_r.prod);
              acc_r   <= '0;
              state_r <= B_MUL;
            end
          end
        end
        B_EMIT: begin
          if (out_adv) begin
            out_valid_r      <= 1'b1;
            out_local_row    <= row_r;
            out_local_col    <= col_r;
            out_global_row   <= GDOF_W'({nr, 1'b0}) + GDOF_W'(nr) + GDOF_W'(ra);
            out_global_col   <= GDOF_W'({nc, 1'b0}) + GDOF_W'(nc) + GDOF_W'(ca);
            out_row_is_fixed <= rn ? bar_r.fix1[ra] : bar_r.fix0[ra];
            out_col_is_fixed <= cn ? bar_r.fix1[ca] : bar_r.fix0[ca];
            out_stiffness    <= val;
            out_zero_length  <= bar_r.zero;
            out_last_entry   <= (row_r == LAST_DOF) && (col_r == LAST_DOF);
            if (col_r == LAST_DOF) begin
              col_r <= '0;
              row_r <= row_r + 3'd1;
              if (row_r == LAST_DOF) state_r <= B_IDLE;
            end else begin
              col_r <= col_r + 3'd1;
            end
          end
        end
        default: state_r <= B_IDLE;
      endcase
    end
  end

endmodule

// ===== src/space_truss_element_stiffness.sv =====
// Top level of the space truss element stiffness block.
// Depends on stes_pkg, stes_front, stes_queue and stes_back.
//
// Usage: each request on the input channel describes one two-node bar (end coordinates in
// Q16.16, modulus in Q32.16, area in Q16.16, node numbers and per-axis fixed flags). For
// every bar the block returns 36 requests on the output channel, the 6x6 element stiffness
// matrix in row-major order, each tagged with local and global degree-of-freedom numbers,
// fixed flags, a zero-length flag and a marker on the 36th entry. Stiffness is Q40.24,
// saturated. Both channels use valid/ready; a request moves when both are high.
//
// Operation: for each bar the front end takes the request, forms the squared length and
// E*A, runs the bit-pair square root and the three cosine divisions, and hands the bar on.
// The back end forms the six distinct magnitudes, each a sliced 32-bit multiply chain and
// an 88-step restoring division by the bar length, and then streams the 36 entries. The
// back-end divider sets the sustained rate; the front end prepares the next bars meanwhile,
// held in a short queue.
//
// Reset (synchronous, rst_n low) empties the queue and returns both ends to idle. When the
// receiver stalls, the current entry holds in the output register and the back end waits;
// the front end keeps accepting bars until the queue fills.
module space_truss_element_stiffness #(
  parameter int QUEUE_DEPTH = stes_pkg::QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_second_z,
  input  logic [47:0]        in_modulus,
  input  logic [31:0]        in_area,
  input  logic [11:0]        in_first_node,
  input  logic [11:0]        in_second_node,
  input  logic [2:0]         in_first_fixed,
  input  logic [2:0]         in_second_fixed,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_local_row,
  output logic [2:0]         out_local_col,
  output logic [13:0]        out_global_row,
  output logic [13:0]        out_global_col,
  output logic               out_row_is_fixed,
  output logic               out_col_is_fixed,
  output logic signed [63:0] out_stiffness,
  output logic               out_zero_length,
  output logic               out_last_entry
);
  import stes_pkg::*;

  // Prepared bar leaving the front end, and the one the back end pops.
  bar_t front_bar, back_bar;
  logic front_valid, front_ready, back_valid, back_ready;

  stes_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_x      (in_first_x),
    .in_first_y      (in_first_y),
    .in_first_z      (in_first_z),
    .in_second_x     (in_second_x),
    .in_second_y     (in_second_y),
    .in_second_z     (in_second_z),
    .in_modulus      (in_modulus),
    .in_area         (in_area),
    .in_first_node   (in_first_node),
    .in_second_node  (in_second_node),
    .in_first_fixed  (in_first_fixed),
    .in_second_fixed (in_second_fixed),
    .bar_valid       (front_valid),
    .bar_ready       (front_ready),
    .bar             (front_bar)
  );

  // The queue lets the front end start the next bar while the back end is still busy.
  stes_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (front_valid),
    .wr_ready (front_ready),
    .wr_data  (front_bar),
    .rd_valid (back_valid),
    .rd_ready (back_ready),
    .rd_data  (back_bar)
  );

  stes_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .bar_valid        (back_valid),
    .bar_ready        (back_ready),
    .bar              (back_bar),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_local_row    (out_local_row),
    .out_local_col    (out_local_col),
    .out_global_row   (out_global_row),
    .out_global_col   (out_global_col),
    .out_row_is_fixed (out_row_is_fixed),
    .out_col_is_fixed (out_col_is_fixed),
    .out_stiffness    (out_stiffness),
    .out_zero_length  (out_zero_length),
    .out_last_entry   (out_last_entry)
  );

  // The end-of-element marker may only appear on the bottom-right entry and nowhere else.
  a_last_corner: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_last_entry) |-> (out_local_row == LAST_DOF && out_local_col == LAST_DOF))
    else $error("last entry marker away from the bottom-right corner");

  // A zero-length bar must give a zero matrix.
  a_zero_bar: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_zero_length) |-> (out_stiffness == '0))
    else $error("zero-length bar produced a nonzero entry");

endmodule

// ===== dv/stes_checker.sv =====
// Checker for the space truss element stiffness block: predicts the 36 matrix entries of
// every bar request taken in and compares each output request against them. Uses stes_pkg.
module stes_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [31:0] in_first_x,
  input  logic signed [31:0] in_first_y,
  input  logic signed [31:0] in_first_z,
  input  logic signed [31:0] in_second_x,
  input  logic signed [31:0] in_second_y,
  input  logic signed [31:0] in_second_z,
  input  logic [47:0]        in_modulus,
  input  logic [31:0]        in_area,
  input  logic [11:0]        in_first_node,
  input  logic [11:0]        in_second_node,
  input  logic [2:0]         in_first_fixed,
  input  logic [2:0]         in_second_fixed,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [2:0]         out_local_row,
  input  logic [2:0]         out_local_col,
  input  logic [13:0]        out_global_row,
  input  logic [13:0]        out_global_col,
  input  logic               out_row_is_fixed,
  input  logic               out_col_is_fixed,
  input  logic signed [63:0] out_stiffness,
  input  logic               out_zero_length,
  input  logic               out_last_entry,
  output int                 mismatches,
  output int                 entries_pending
);
  import stes_pkg::*;

  typedef struct packed {
    logic [2:0]         row;
    logic [2:0]         col;
    logic [13:0]        grow;
    logic [13:0]        gcol;
    logic               rfix;
    logic               cfix;
    logic [STIFF_W-1:0] stiff;
    logic               zero;
    logic               last;
  } entry_t;

  entry_t entry_q[$];
  int     fails;

  assign mismatches      = fails;
  assign entries_pending = entry_q.size();

  function automatic logic [LEN_W-1:0] floor_sqrt(input logic [67:0] s);
    logic [LEN_W+1:0] r;
    logic [LEN_W+1:0] t;
    r = '0;
    for (int b = 34; b >= 0; b--) begin
      t = r | (35'd1 << b);
      if ({34'd0, t} * {34'd0, t} <= {2'd0, s}) r = t;
    end
    return r[LEN_W-1:0];
  endfunction

  // Expand one bar into its matrix entries, in row-major order.
  task automatic push_matrix();
    logic signed [32:0] d [3];
    logic [32:0]        u [3];
    logic [63:0]        c [3];
    logic               neg [3];
    logic [31:0]        p0 [3];
    logic [31:0]        p1 [3];
    logic [67:0]        s;
    logic [63:0]        len;
    logic               zero;
    logic [79:0]        prod;
    logic [127:0]       num;
    logic [127:0]       quo;
    logic [63:0]        mag [3][3];
    logic [63:0]        m;
    logic [11:0]        node [2];
    logic [2:0]         fix [2];
    entry_t             e;
    int                 rn, ra, cn, ca;
    p0[0] = in_first_x;  p0[1] = in_first_y;  p0[2] = in_first_z;
    p1[0] = in_second_x; p1[1] = in_second_y; p1[2] = in_second_z;
    node[0] = in_first_node;  node[1] = in_second_node;
    fix[0]  = in_first_fixed; fix[1]  = in_second_fixed;
    s = '0;
    for (int a = 0; a < 3; a++) begin
      d[a]   = $signed({p1[a][31], p1[a]}) - $signed({p0[a][31], p0[a]});
      neg[a] = d[a] < 0;
      u[a]   = neg[a] ? -d[a] : d[a];
      s      = s + {35'd0, u[a]} * {35'd0, u[a]};
    end
    zero = (s == 0);
    len  = zero ? 64'd1 : {31'd0, floor_sqrt(s)};
    prod = {32'd0, in_modulus} * {48'd0, in_area};
    for (int a = 0; a < 3; a++) c[a] = {7'd0, u[a], 24'd0} / len;
    for (int a = 0; a < 3; a++) begin
      for (int b = 0; b < 3; b++) begin
        num = {48'd0, prod} * {64'd0, c[a] * c[b]};
        quo = (num >> 40) / {64'd0, len};
        mag[a][b] = (quo > {64'd0, NEG_MAX}) ? NEG_MAX : quo[63:0];
      end
    end
    for (int r = 0; r < DOF; r++) begin
      for (int k = 0; k < DOF; k++) begin
        rn = r / 3; ra = r % 3; cn = k / 3; ca = k % 3;
        m = zero ? 64'd0 : mag[ra][ca];
        e.row  = r[2:0];
        e.col  = k[2:0];
        e.grow = 14'(node[rn] * 3 + ra);
        e.gcol = 14'(node[cn] * 3 + ca);
        e.rfix = fix[rn][ra];
        e.cfix = fix[cn][ca];
        // Sign flips once for each negative direction and once across nodes.
        if ((neg[ra] != neg[ca]) != (rn != cn)) e.stiff = -m;
        else e.stiff = (m > POS_MAX) ? POS_MAX : m;
        e.zero = zero;
        e.last = (r == DOF - 1) && (k == DOF - 1);
        entry_q.push_back(e);
      end
    end
  endtask

  always @(posedge clk) begin
    entry_t got;
    entry_t want;
    if (!rst_n) begin
      fails <= 0;
    end else begin
      if (in_valid && in_ready) push_matrix();
      if (out_valid && out_ready) begin
        got = '{out_local_row, out_local_col, out_global_row, out_global_col,
                out_row_is_fixed, out_col_is_fixed, out_stiffness, out_zero_length,
                out_last_entry};
        if (entry_q.size() == 0) begin
          if (fails < 10) $display("unexpected entry: %p", got);
          fails <= fails + 1;
        end else begin
          want = entry_q.pop_front();
          if (got !== want) begin
            if (fails < 10) $display("entry mismatch: expected %p actual %p", want, got);
            fails <= fails + 1;
          end
        end
      end
    end
  end

endmodule

// ===== dv/space_truss_element_stiffness_tb.sv =====
// Top of the space truss element stiffness testbench: clock, reset, bar stimulus, receiver
// back-pressure, watchdog and verdict. Depends on stes_pkg, stes_checker and the block.
module space_truss_element_stiffness_tb;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [31:0] in_first_x, in_first_y, in_first_z;
  logic signed [31:0] in_second_x, in_second_y, in_second_z;
  logic [47:0]        in_modulus;
  logic [31:0]        in_area;
  logic [11:0]        in_first_node, in_second_node;
  logic [2:0]         in_first_fixed, in_second_fixed;
  logic               out_valid;
  logic               out_ready;
  logic [2:0]         out_local_row, out_local_col;
  logic [13:0]        out_global_row, out_global_col;
  logic               out_row_is_fixed, out_col_is_fixed;
  logic signed [63:0] out_stiffness;
  logic               out_zero_length, out_last_entry;

  int mismatches;
  int entries_pending;
  int bars_sent;
  int cycle_count;
  int quiet_cycles;
  // Bars in this window are sent back to back; the receiver is also always
  // ready in a separate window of cycles, set in its own process.
  localparam int CALM_FIRST = 60;
  localparam int CALM_LAST  = 75;
  localparam int HOLD_START = 30;
  localparam int HOLD_LEN   = 4000;
  localparam int WATCHDOG   = 30000;

  space_truss_element_stiffness i_dut (.*);

  stes_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // The receiver stalls at random, except for one calm stretch of cycles and one long
  // hold-off that starts once enough bar requests have gone in, so the queue fills up.
  initial begin
    int hold;
    hold = 0;
    out_ready = 1'b0;
    forever begin
      @(posedge clk);
      if (hold == 0 && bars_sent == HOLD_START) hold = HOLD_LEN;
      if (hold > 1) begin
        hold--;
        out_ready <= 1'b0;
      end else begin
        if (hold == 1) hold = -1;
        if (cycle_count > 20000 && cycle_count < 35000) out_ready <= 1'b1;
        else out_ready <= ($urandom_range(99) >= 37);
      end
    end
  end

  always @(posedge clk) cycle_count <= rst_n ? cycle_count + 1 : 0;

  // Watchdog: cycles in which neither channel moved a request.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG) begin
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one bar request and hold it until the block takes it.
  task automatic send_bar(input logic [31:0] fx, input logic [31:0] fy, input logic [31:0] fz,
                          input logic [31:0] sx, input logic [31:0] sy, input logic [31:0] sz,
                          input logic [47:0] e, input logic [31:0] a,
                          input logic [11:0] n0, input logic [11:0] n1,
                          input logic [2:0] f0, input logic [2:0] f1);
    if (!(bars_sent >= CALM_FIRST && bars_sent < CALM_LAST) && $urandom_range(99) < 37) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < 37);
    end
    in_valid        <= 1'b1;
    in_first_x      <= fx;
    in_first_y      <= fy;
    in_first_z      <= fz;
    in_second_x     <= sx;
    in_second_y     <= sy;
    in_second_z     <= sz;
    in_modulus      <= e;
    in_area         <= a;
    in_first_node   <= n0;
    in_second_node  <= n1;
    in_first_fixed  <= f0;
    in_second_fixed <= f1;
    do @(posedge clk); while (!in_ready);
    bars_sent++;
  endtask

  // Random coordinate near a base point, so lengths span many scales.
  function automatic logic [31:0] near(input logic [31:0] base);
    int sh;
    sh = $urandom_range(31);
    return base + ($urandom() >> sh) - ($urandom() >> sh);
  endfunction

  initial begin
    logic [31:0] bx, by, bz;
    rst_n = 1'b0;
    in_valid = 1'b0;
    bars_sent = 0;
    {in_first_x, in_first_y, in_first_z, in_second_x, in_second_y, in_second_z} = '0;
    {in_modulus, in_area, in_first_node, in_second_node} = '0;
    {in_first_fixed, in_second_fixed} = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed bars: axis-aligned, negative directions, extreme coordinates, a zero-length
    // bar, saturating stiffness, zero modulus, equal node numbers and the top node number.
    send_bar(0, 0, 0, 32'h10000, 0, 0, 48'h10000, 32'h10000, 0, 1, 3'd0, 3'd7);
    send_bar(0, 0, 0, 0, 32'hFFFF0000, 0, 48'h20000, 32'h8000, 2, 3, 3'd5, 3'd2);
    send_bar(32'h30000, 32'h40000, 0, 0, 0, 32'h50000, 48'h123456, 32'h23456, 7, 4095,
             3'd1, 3'd4);
    send_bar(32'h80000000, 32'h80000000, 32'h80000000, 32'h7FFFFFFF, 32'h7FFFFFFF,
             32'h7FFFFFFF, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 4095, 4095, 3'd7, 3'd7);
    send_bar(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h80000000, 32'h80000000, 32'h80000000,
             32'h7FFFFFFF, 48'h10000, 32'h10000, 0, 0, 3'd3, 3'd6);
    send_bar(32'h12345, 32'hFFFF1234, 32'h777, 32'h12345, 32'hFFFF1234, 32'h777,
             48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 10, 11, 3'd7, 3'd0);
    send_bar(0, 0, 0, 1, 0, 0, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 100, 200, 3'd2, 3'd1);
    send_bar(0, 0, 0, 1, 1, 1, 48'hFFFFFFFFFFFF, 32'hFFFFFFFF, 5, 6, 3'd4, 3'd5);
    send_bar(5, 5, 5, 4, 6, 4, 48'h0, 32'hFFFFFFFF, 1, 2, 3'd0, 3'd0);
    send_bar(0, 0, 0, 32'h10000, 32'h10000, 0, 48'h800000000000, 32'h0, 4000, 4095,
             3'd6, 3'd3);
    send_bar(32'hFFFFFFFF, 0, 32'h1, 32'h1, 32'hFFFFFFFF, 32'hFFFFFFFF, 48'hABCDEF012345,
             32'h89ABCDEF, 4094, 1, 3'd7, 3'd7);

    // Random bars: random scales of length, modulus and area, all node numbers and flags.
    repeat (100) begin
      if ($urandom_range(3) == 0) begin
        bx = $urandom(); by = $urandom(); bz = $urandom();
        send_bar(bx, by, bz, $urandom(), $urandom(), $urandom(),
                 48'({$urandom(), $urandom()} >> $urandom_range(16)),
                 $urandom() >> $urandom_range(31), 12'($urandom()), 12'($urandom()),
                 3'($urandom()), 3'($urandom()));
      end else begin
        bx = $urandom(); by = $urandom(); bz = $urandom();
        send_bar(bx, by, bz, near(bx), near(by), ($urandom_range(9) == 0) ? bz : near(bz),
                 48'({$urandom(), $urandom()} >>
                     ($urandom_range(16) + 16 * $urandom_range(1))),
                 $urandom() >> $urandom_range(31), 12'($urandom()), 12'($urandom()),
                 3'($urandom()), 3'($urandom()));
      end
    end
    in_valid <= 1'b0;

    while (entries_pending != 0) @(posedge clk);
    repeat (1000) @(posedge clk);
    if (mismatches == 0 && entries_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
